/* sv/pid_controller_serial_parallel_core_macros.svh */
// Assertion macros for the PID controller core.
// Expects signals named clk and rst in the including scope.
`ifndef PID_CONTROLLER_SERIAL_PARALLEL_CORE_MACROS_SVH
`define PID_CONTROLLER_SERIAL_PARALLEL_CORE_MACROS_SVH

// same-cycle implication
`define PCSP_CHECK_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PCSP_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/pcsp_pkg.sv */
// Shared types and constants of the PID controller core.
// No dependencies.
package pcsp_pkg;

  localparam int DATA_W        = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int REG_IDX_W     = 3;

  typedef logic signed [DATA_W-1:0] data_t;

  localparam data_t DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam data_t DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  localparam logic FORM_SERIAL   = 1'b0;
  localparam logic FORM_PARALLEL = 1'b1;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_FORM     = 3'd0,
    REG_PROP     = 3'd1,
    REG_INT      = 3'd2,
    REG_DERIV    = 3'd3,
    REG_INTEG_HI = 3'd4,
    REG_INTEG_LO = 3'd5,
    REG_DRIVE_HI = 3'd6,
    REG_DRIVE_LO = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic  form;
    data_t prop_gain;
    data_t int_gain;
    data_t deriv_gain;
    data_t integ_upper;
    data_t integ_lower;
    data_t drive_upper;
    data_t drive_lower;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic err;
    logic clr;
    logic mulp;
    logic muli;
    logic iadd;
    logic iclamp;
    logic muld;
    logic sump;
    logic sumd;
    logic dclamp;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic clear;
    logic form;
  } sts_t;

endpackage

/* sv/pcsp_regs.sv */
// Configuration register file of the PID controller core.
// Depends on pcsp_pkg.
module pcsp_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [pcsp_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [pcsp_pkg::DATA_W-1:0]    cfg_data,
  output pcsp_pkg::cfg_t                 cfg
);
  import pcsp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (reg_idx_t'(cfg_index))
        REG_FORM:     cfg.form        <= cfg_data[0];
        REG_PROP:     cfg.prop_gain   <= data_t'(cfg_data);
        REG_INT:      cfg.int_gain    <= data_t'(cfg_data);
        REG_DERIV:    cfg.deriv_gain  <= data_t'(cfg_data);
        REG_INTEG_HI: cfg.integ_upper <= data_t'(cfg_data);
        REG_INTEG_LO: cfg.integ_lower <= data_t'(cfg_data);
        REG_DRIVE_HI: cfg.drive_upper <= data_t'(cfg_data);
        REG_DRIVE_LO: cfg.drive_lower <= data_t'(cfg_data);
      endcase
    end
  end

endmodule

/* sv/pcsp_ctrl.sv */
// Sequencer of the PID controller core: steps one item through the datapath.
// Depends on pcsp_pkg.
module pcsp_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  output logic           m_tvalid,
  input  logic           m_tready,
  input  pcsp_pkg::sts_t sts,
  output pcsp_pkg::cmd_t cmd
);
  import pcsp_pkg::*;

  typedef enum logic [10:0] {
    IDLE   = 11'b00000000001,
    ERR    = 11'b00000000010,
    MULP   = 11'b00000000100,
    MULI   = 11'b00000001000,
    IADD   = 11'b00000010000,
    ICLAMP = 11'b00000100000,
    SUMP   = 11'b00001000000,
    SUMD   = 11'b00010000000,
    DCLAMP = 11'b00100000000,
    DONE   = 11'b01000000000,
    SPARE  = 11'b10000000000
  } state_t;

  state_t state, state_next;
  logic   slot_free;

  assign s_tready  = (state == IDLE);
  assign slot_free = !m_tvalid || m_tready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      IDLE: begin
        cmd.load = s_tvalid;
        if (s_tvalid) state_next = ERR;
      end
      ERR: begin
        cmd.err    = 1'b1;
        cmd.clr    = sts.clear;
        state_next = sts.clear ? DONE : MULP;
      end
      MULP: begin
        cmd.mulp   = 1'b1;
        state_next = MULI;
      end
      MULI: begin
        cmd.muli   = 1'b1;
        state_next = IADD;
      end
      IADD: begin
        cmd.iadd   = 1'b1;
        state_next = ICLAMP;
      end
      ICLAMP: begin
        cmd.iclamp = 1'b1;
        cmd.muld   = sts.form;
        state_next = SUMP;
      end
      SUMP: begin
        cmd.sump   = 1'b1;
        state_next = sts.form ? SUMD : DCLAMP;
      end
      SUMD: begin
        cmd.sumd   = 1'b1;
        state_next = DCLAMP;
      end
      DCLAMP: begin
        cmd.dclamp = 1'b1;
        state_next = DONE;
      end
      DONE: begin
        cmd.emit = slot_free;
        if (slot_free) state_next = IDLE;
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

endmodule

/* sv/pcsp_dp.sv */
// Datapath of the PID controller core: one shared multiplier, saturating
// adder and clamps, controller state and output registers. Depends on pcsp_pkg.
module pcsp_dp #(
  parameter int FRAC_BITS = pcsp_pkg::FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  pcsp_pkg::cfg_t  cfg,
  input  pcsp_pkg::cmd_t  cmd,
  output pcsp_pkg::sts_t  sts,
  input  pcsp_pkg::data_t reference,
  input  pcsp_pkg::data_t feedback,
  input  logic            clear_state,
  output pcsp_pkg::data_t drive,
  output pcsp_pkg::data_t control_error,
  output pcsp_pkg::data_t integral_value
);
  import pcsp_pkg::*;

  localparam int ProdW = 2 * DATA_W;

  data_t ref_r, fb_r, err_r, diff_r, pterm_r, term_r, dterm_r, acc_r;
  data_t integ, prev;
  logic  clear_r;
  data_t mul_a, mul_b, mul_res;
  logic signed [ProdW-1:0] prod;

  function automatic data_t sat_add(input data_t a, input data_t b, input logic sub);
    logic signed [DATA_W:0] s;
    s = sub ? ({a[DATA_W-1], a} - {b[DATA_W-1], b}) : ({a[DATA_W-1], a} + {b[DATA_W-1], b});
    if (s[DATA_W] != s[DATA_W-1]) return s[DATA_W] ? DATA_MIN : DATA_MAX;
    return s[DATA_W-1:0];
  endfunction

  // floor shift by FRAC_BITS, then saturate
  function automatic data_t fx(input logic signed [ProdW-1:0] p);
    logic signed [ProdW-1:0] q;
    logic [ProdW-DATA_W:0]   hi;
    q  = p >>> FRAC_BITS;
    hi = q[ProdW-1:DATA_W-1];
    if (&hi || ~|hi) return q[DATA_W-1:0];
    return q[ProdW-1] ? DATA_MIN : DATA_MAX;
  endfunction

  // upper limit first, lower limit wins when crossed
  function automatic data_t clampv(input data_t v, input data_t upper, input data_t lower);
    data_t r;
    r = (v > upper) ? upper : v;
    return (r < lower) ? lower : r;
  endfunction

  always_comb begin
    priority if (cmd.mulp) begin
      mul_a = cfg.prop_gain;
      mul_b = err_r;
    end else if (cmd.muli) begin
      mul_a = cfg.int_gain;
      mul_b = cfg.form ? err_r : pterm_r;
    end else begin
      mul_a = cfg.deriv_gain;
      mul_b = diff_r;
    end
  end

  assign prod    = mul_a * mul_b;
  assign mul_res = fx(prod);

  assign sts.clear = clear_r;
  assign sts.form  = cfg.form;

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_r <= 1'b0;
      integ   <= '0;
      prev    <= '0;
    end else begin
      if (cmd.load) clear_r <= clear_state;
      if (cmd.clr) begin
        integ <= '0;
        prev  <= '0;
      end
      if (cmd.iadd)   integ <= sat_add(integ, term_r, 1'b0);
      if (cmd.iclamp) integ <= clampv(integ, cfg.integ_upper, cfg.integ_lower);
      if (cmd.sump && cfg.form) prev <= err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ref_r <= reference;
      fb_r  <= feedback;
    end
    if (cmd.err)  err_r <= sat_add(ref_r, fb_r, 1'b1);
    if (cmd.clr)  acc_r <= '0;
    if (cmd.mulp) begin
      pterm_r <= mul_res;
      diff_r  <= sat_add(err_r, prev, 1'b1);
    end
    if (cmd.muli)   term_r  <= mul_res;
    if (cmd.muld)   dterm_r <= mul_res;
    if (cmd.sump)   acc_r   <= sat_add(pterm_r, integ, 1'b0);
    if (cmd.sumd)   acc_r   <= sat_add(acc_r, dterm_r, 1'b0);
    if (cmd.dclamp) acc_r   <= clampv(acc_r, cfg.drive_upper, cfg.drive_lower);
    if (cmd.emit) begin
      drive          <= acc_r;
      control_error  <= err_r;
      integral_value <= integ;
    end
  end

endmodule

/* sv/pid_controller_serial_parallel_core.sv */
// Top level of the PID controller core (serial PI / parallel PID forms).
// Depends on pcsp_pkg, pcsp_regs, pcsp_ctrl, pcsp_dp and the macros header.
//
//   channel   direction  handshake          payload
//   s_*       in         tvalid/tready      tdata: reference, feedback; tuser: clear_state
//   m_*       out        tvalid/tready      tdata: drive, control_error, integral_value
//   cfg_*     in         cfg_write          cfg_index, cfg_data
//
// One item at a time, stepped by the sequencer through one shared multiplier;
// serial form skips SUMD, and a clear request goes from ERR straight to DONE.
// The next item is accepted while a result waits in the output register; a
// stalled output holds the sequencer in DONE.
// rst is synchronous: clears configuration, integrator and previous error.
`include "pid_controller_serial_parallel_core_macros.svh"

module pid_controller_serial_parallel_core #(
  parameter int FRAC_BITS = pcsp_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [pcsp_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [pcsp_pkg::DATA_W-1:0]    cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [2*pcsp_pkg::DATA_W-1:0]  s_tdata,   // reference, feedback
  input  logic [0:0]                     s_tuser,   // clear_state
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [3*pcsp_pkg::DATA_W-1:0]  m_tdata    // drive, control_error, integral_value
);
  import pcsp_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd;
  sts_t  sts;
  data_t drive, control_error, integral_value;

  pcsp_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pcsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pcsp_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .cmd            (cmd),
    .sts            (sts),
    .reference      (data_t'(s_tdata[DATA_W-1:0])),
    .feedback       (data_t'(s_tdata[2*DATA_W-1:DATA_W])),
    .clear_state    (s_tuser[0]),
    .drive          (drive),
    .control_error  (control_error),
    .integral_value (integral_value)
  );

  assign m_tdata = {integral_value, control_error, drive};

  `PCSP_CHECK_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "second item taken while busy")
  `PCSP_CHECK_NOW(a_emit_busy, cmd.emit, !s_tready, "result issued while idle")
  `PCSP_CHECK_NOW(a_rose_emit, $rose(m_tvalid), $past(cmd.emit), "result valid without issue")
  `PCSP_CHECK_NOW(a_one_op, 1'b1, $onehot0({cmd.load, cmd.err, cmd.mulp, cmd.muli, cmd.iadd, cmd.iclamp, cmd.sump, cmd.sumd, cmd.dclamp, cmd.emit}), "overlapping datapath ops")

endmodule

/* dv/pid_drive_checker.sv */
// Checker for the PID controller core: follows register writes, predicts each
// result on input acceptance and compares the results as they leave.
// Depends on pcsp_pkg for the register index and configuration types.
module pid_drive_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [pcsp_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [pcsp_pkg::DATA_W-1:0]    cfg_data,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [2*pcsp_pkg::DATA_W-1:0]  s_tdata,   // reference, feedback
  input  logic [0:0]                     s_tuser,   // clear_state
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [3*pcsp_pkg::DATA_W-1:0]  m_tdata,   // drive, control_error, integral_value
  output int                             outstanding,
  output int                             mismatches
);
  timeunit 1ns;
  timeprecision 1ps;
  import pcsp_pkg::*;

  typedef struct packed {
    data_t integral_value;
    data_t control_error;
    data_t drive;
  } pid_result_t;

  cfg_t        settings;
  data_t       integ_acc;
  data_t       last_error;
  pid_result_t pending_drive_q[$];
  pid_result_t got, want;
  int          results_seen = 0;

  function automatic data_t saturate(longint v);
    if (v > longint'(DATA_MAX)) return DATA_MAX;
    if (v < longint'(DATA_MIN)) return DATA_MIN;
    return data_t'(v);
  endfunction

  // exact product, floor shift, saturate
  function automatic data_t q_mult(data_t a, data_t b);
    longint prod;
    prod = longint'(a) * longint'(b);
    return saturate(prod >>> FRAC_BITS_DEF);
  endfunction

  // upper limit first, so a crossed lower limit wins
  function automatic data_t bound(data_t v, data_t upper, data_t lower);
    data_t r;
    r = v;
    if (r > upper) r = upper;
    if (r < lower) r = lower;
    return r;
  endfunction

  function automatic pid_result_t compute_pid_step(data_t reference, data_t feedback,
                                                   logic clear);
    pid_result_t res;
    data_t err, pterm, dterm, sum;
    err = saturate(longint'(reference) - longint'(feedback));
    res.control_error = err;
    if (clear) begin
      integ_acc          = '0;
      last_error         = '0;
      res.drive          = '0;
      res.integral_value = '0;
      return res;
    end
    pterm = q_mult(settings.prop_gain, err);
    if (settings.form == FORM_SERIAL) begin
      integ_acc = saturate(longint'(integ_acc) + longint'(q_mult(settings.int_gain, pterm)));
      integ_acc = bound(integ_acc, settings.integ_upper, settings.integ_lower);
      sum = saturate(longint'(pterm) + longint'(integ_acc));
    end else begin
      integ_acc = saturate(longint'(integ_acc) + longint'(q_mult(settings.int_gain, err)));
      integ_acc = bound(integ_acc, settings.integ_upper, settings.integ_lower);
      dterm = q_mult(settings.deriv_gain,
                     saturate(longint'(err) - longint'(last_error)));
      last_error = err;
      sum = saturate(longint'(pterm) + longint'(integ_acc));
      sum = saturate(longint'(sum) + longint'(dterm));
    end
    res.drive          = bound(sum, settings.drive_upper, settings.drive_lower);
    res.integral_value = integ_acc;
    return res;
  endfunction

  task automatic flag_mismatch(string note);
    $display("[%0t] mismatch: %s", $realtime, note);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      settings   = '0;
      integ_acc  = '0;
      last_error = '0;
      pending_drive_q.delete();
      outstanding <= 0;
    end else begin
      if (cfg_write) begin
        case (reg_idx_t'(cfg_index))
          REG_FORM:     settings.form        = cfg_data[0];
          REG_PROP:     settings.prop_gain   = cfg_data;
          REG_INT:      settings.int_gain    = cfg_data;
          REG_DERIV:    settings.deriv_gain  = cfg_data;
          REG_INTEG_HI: settings.integ_upper = cfg_data;
          REG_INTEG_LO: settings.integ_lower = cfg_data;
          REG_DRIVE_HI: settings.drive_upper = cfg_data;
          REG_DRIVE_LO: settings.drive_lower = cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got = pid_result_t'(m_tdata);
        if (pending_drive_q.size() == 0) begin
          flag_mismatch($sformatf("result with nothing pending: %h", m_tdata));
        end else begin
          want = pending_drive_q.pop_front();
          if (got.drive !== want.drive)
            flag_mismatch($sformatf("result %0d drive %h, want %h",
                                    results_seen, got.drive, want.drive));
          if (got.control_error !== want.control_error)
            flag_mismatch($sformatf("result %0d control_error %h, want %h",
                                    results_seen, got.control_error, want.control_error));
          if (got.integral_value !== want.integral_value)
            flag_mismatch($sformatf("result %0d integral_value %h, want %h",
                                    results_seen, got.integral_value, want.integral_value));
        end
        results_seen++;
      end
      if (s_tvalid && s_tready)
        pending_drive_q.push_back(compute_pid_step(data_t'(s_tdata[DATA_W-1:0]),
                                                   data_t'(s_tdata[2*DATA_W-1:DATA_W]),
                                                   s_tuser[0]));
      outstanding <= pending_drive_q.size();
    end
  end

endmodule

/* dv/pid_controller_serial_parallel_core_test.sv */
// Testbench top for the PID controller core: clock, reset, register writes,
// sample stimulus with random gaps and output stalls, watchdog and verdict.
// Depends on pcsp_pkg, the core and pid_drive_checker.
module pid_controller_serial_parallel_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pcsp_pkg::*;

  localparam data_t Q_ONE          = 32'sh0001_0000;
  localparam int    WATCHDOG_LIMIT = 2000;
  localparam int    RANDOM_PHASES  = 10;
  localparam int    PHASE_ITEMS    = 85;
  localparam int unsigned GAIN_SPAN  = 32'h0004_0000;  // +-4.0
  localparam int unsigned LEVEL_SPAN = 32'h0100_0000;  // +-256.0

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [REG_IDX_W-1:0]  cfg_index = '0;
  logic [DATA_W-1:0]     cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [2*DATA_W-1:0]   s_tdata = '0;   // reference, feedback
  logic [0:0]            s_tuser = '0;   // clear_state
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [3*DATA_W-1:0]   m_tdata;        // drive, control_error, integral_value

  int outstanding, mismatches;
  bit send_gaps = 1'b1;
  bit ready_stalls = 1'b1;
  int ready_hold = 0;
  int idle_cycles = 0;
  int samples_sent = 0;
  int clears_sent = 0;
  int settings_applied = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pid_controller_serial_parallel_core uut (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata
  );

  pid_drive_checker drive_monitor (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata,
    .outstanding, .mismatches
  );

  // random output stalls, each held by a countdown in ready_hold
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (ready_stalls && $urandom_range(0, 5) == 0) begin
      ready_hold <= $urandom_range(0, 18);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (cfg_write || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic data_t rand_q16(int unsigned span);
    case ($urandom_range(0, 9))
      0: return data_t'($urandom);
      1: begin
        case ($urandom_range(0, 4))
          0:       return DATA_MAX;
          1:       return DATA_MIN;
          2:       return '0;
          3:       return data_t'(1);
          default: return '1;
        endcase
      end
      default: return data_t'($urandom_range(0, 2 * span)) - data_t'(span);
    endcase
  endfunction

  function automatic void pick_limits(output data_t upper, output data_t lower);
    data_t a, b;
    a = rand_q16(LEVEL_SPAN);
    b = rand_q16(LEVEL_SPAN);
    case ($urandom_range(0, 7))
      0: begin upper = (a < b) ? a : b; lower = (a < b) ? b : a; end  // crossed
      1: begin upper = DATA_MAX; lower = DATA_MIN; end
      default: begin upper = (a > b) ? a : b; lower = (a > b) ? b : a; end
    endcase
  endfunction

  function automatic cfg_t make_settings(logic form, data_t kp, data_t ki, data_t kd,
                                         data_t iu, data_t il, data_t du, data_t dl);
    cfg_t c;
    c.form        = form;
    c.prop_gain   = kp;
    c.int_gain    = ki;
    c.deriv_gain  = kd;
    c.integ_upper = iu;
    c.integ_lower = il;
    c.drive_upper = du;
    c.drive_lower = dl;
    return c;
  endfunction

  function automatic cfg_t random_settings();
    cfg_t c;
    c.form       = $urandom_range(0, 1) ? FORM_PARALLEL : FORM_SERIAL;
    c.prop_gain  = rand_q16(GAIN_SPAN);
    c.int_gain   = rand_q16(GAIN_SPAN);
    c.deriv_gain = rand_q16(GAIN_SPAN);
    pick_limits(c.integ_upper, c.integ_lower);
    pick_limits(c.drive_upper, c.drive_lower);
    return c;
  endfunction

  task automatic apply_settings(cfg_t c);
    reg_idx_t r;
    r = REG_FORM;
    repeat (r.num()) begin
      cfg_write <= 1'b1;
      cfg_index <= r;
      case (r)
        REG_FORM:     cfg_data <= {31'($urandom), c.form};
        REG_PROP:     cfg_data <= c.prop_gain;
        REG_INT:      cfg_data <= c.int_gain;
        REG_DERIV:    cfg_data <= c.deriv_gain;
        REG_INTEG_HI: cfg_data <= c.integ_upper;
        REG_INTEG_LO: cfg_data <= c.integ_lower;
        REG_DRIVE_HI: cfg_data <= c.drive_upper;
        REG_DRIVE_LO: cfg_data <= c.drive_lower;
        default:      cfg_data <= '0;
      endcase
      @(posedge clk);
      r = r.next();
    end
    cfg_write <= 1'b0;
    settings_applied++;
  endtask

  // block is idle once every result is out and the sequencer has settled
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic send_sample(data_t reference, data_t feedback, logic clear);
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {feedback, reference};
    s_tuser  <= clear;
    do @(posedge clk); while (!s_tready);
    samples_sent++;
    if (clear) clears_sent++;
  endtask

  // setpoint held for a run while feedback wanders around it
  task automatic random_items(int count);
    int run_left;
    int unsigned spread;
    data_t target;
    run_left = 0;
    spread   = 0;
    target   = '0;
    repeat (count) begin
      if (run_left == 0) begin
        run_left = $urandom_range(4, 20);
        target   = rand_q16(LEVEL_SPAN);
        spread   = $urandom_range(0, 32'h000F_FFFF);
      end
      run_left--;
      case ($urandom_range(0, 31))
        0:       send_sample(rand_q16(LEVEL_SPAN), rand_q16(LEVEL_SPAN), 1'b1);
        1, 2:    send_sample(data_t'($urandom), data_t'($urandom), 1'b0);
        default: send_sample(target,
                             target + data_t'($urandom_range(0, 2 * spread)) - data_t'(spread),
                             1'b0);
      endcase
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // serial form: error saturation, floor rounding, integrator clamp, clear
    drain_results();
    apply_settings(make_settings(FORM_SERIAL, Q_ONE, 32'sh0000_8000, Q_ONE,
                                 4 * Q_ONE, -4 * Q_ONE, 8 * Q_ONE, -8 * Q_ONE));
    send_sample('0, '0, 1'b0);
    send_sample(DATA_MAX, DATA_MIN, 1'b0);
    send_sample(DATA_MIN, DATA_MAX, 1'b0);
    send_sample('1, '0, 1'b0);
    send_sample(3 * Q_ONE, '0, 1'b0);
    send_sample(3 * Q_ONE, '0, 1'b0);
    send_sample(3 * Q_ONE, '0, 1'b0);
    send_sample(DATA_MAX, data_t'(5), 1'b1);
    send_sample(DATA_MIN, '0, 1'b0);

    // parallel form, extreme gains and open limits: term and derivative saturation
    drain_results();
    apply_settings(make_settings(FORM_PARALLEL, 32'shFFFE_8000, DATA_MAX, DATA_MIN,
                                 DATA_MAX, DATA_MIN, DATA_MAX, DATA_MIN));
    send_sample(DATA_MAX, DATA_MIN, 1'b0);
    send_sample(DATA_MIN, DATA_MAX, 1'b0);
    send_sample(data_t'(1), '0, 1'b0);
    send_sample('0, data_t'(1), 1'b0);
    send_sample(Q_ONE, '0, 1'b1);
    send_sample(Q_ONE, '0, 1'b0);
    send_sample('0, '0, 1'b0);

    // crossed limits: lower limit wins
    drain_results();
    apply_settings(make_settings(FORM_PARALLEL, Q_ONE, Q_ONE, 32'sh0000_8000,
                                 -Q_ONE, Q_ONE, -2 * Q_ONE, 2 * Q_ONE));
    send_sample(Q_ONE, '0, 1'b0);
    send_sample(-Q_ONE, '0, 1'b0);
    send_sample('0, '0, 1'b0);
    send_sample(5 * Q_ONE, Q_ONE, 1'b0);

    // zero gains, fully crossed extreme limits
    drain_results();
    apply_settings(make_settings(FORM_SERIAL, '0, '0, '0,
                                 DATA_MIN, DATA_MAX, DATA_MIN, DATA_MAX));
    send_sample(Q_ONE, -Q_ONE, 1'b0);
    send_sample(DATA_MIN, DATA_MIN, 1'b0);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      send_gaps    = (p != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      ready_stalls = (p != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      drain_results();
      apply_settings(random_settings());
      random_items(PHASE_ITEMS);
    end

    drain_results();
    $display("Covered %0d samples (%0d clear requests) under %0d register settings,",
             samples_sent, clears_sent, settings_applied);
    $display("both forms, crossed and extreme limits, random gaps and stalls; %0d mismatches.",
             mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
